// File: src/sbrp_pkg.sv
// Shared types and constants for the STUN binding response parser.
// No dependencies; imported by the parser top level.
`timescale 1ns / 1ps
`default_nettype none

package sbrp_pkg;

   localparam int unsigned OFFSET_BITS_DEFAULT = 17;

   localparam int unsigned HDR_LEN  = 20;
   localparam int unsigned ATTR_HDR = 4;

   localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
   localparam logic [15:0] MSG_TYPE_BINDING_RSP = 16'h0101;
   localparam logic [15:0] KIND_XOR_MAPPED = 16'h0020;
   localparam logic [15:0] KIND_MAPPED = 16'h0001;
   localparam logic [7:0]  FAMILY_V4 = 8'h01;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TXID_HIGH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TXID_MID  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TXID_LOW  = 2'd2;

   typedef struct packed {
      logic        found;
      logic        from_xor;
      logic [31:0] ip_address;
      logic [15:0] mapped_port;
   } verdict_type;

endpackage

`default_nettype wire

// File: src/stun_binding_response_parser.sv
// STUN binding response parser: byte-stream header check, attribute walk, verdict.
// Depends on sbrp_pkg (constants, verdict_type).
//
//  channel | ports                                   | direction | word
//  req     | req_valid/ready, data_byte, last_byte   | in        | one message byte
//  rsp     | rsp_valid/ready, found, from_xor, ...   | out       | one verdict
//  csr     | csr_valid/ready, csr_index, csr_data    | in        | one register write
//
// One byte is taken every cycle while req_ready is high; the byte updates the parser state in the cycle it is
// accepted. The verdict for the final byte is registered in the output register, or in the skid if that is stalled.
// A one-entry skid behind the output register keeps bytes flowing while a verdict waits;
// req_ready drops only when both the output register and the skid hold verdicts.
// Reset (synchronous) clears parser state and registers; csr writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module stun_binding_response_parser
   import sbrp_pkg::*;
#(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_last_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_found,
   output logic                           rsp_from_xor,
   output logic [31:0]                    rsp_ip_address,
   output logic [15:0]                    rsp_mapped_port,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]               csr_data
);

   localparam int unsigned W  = OFFSET_BITS;
   localparam int unsigned CW = OFFSET_BITS + 1;
   localparam logic [W-1:0]  OFF_MAX   = '1;
   localparam logic [W-1:0]  HDR_W     = W'(HDR_LEN);
   localparam logic [CW-1:0] HDR_C     = CW'(HDR_LEN);
   localparam logic [CW-1:0] ATTR_C    = CW'(ATTR_HDR);
   localparam logic [CW-1:0] ALIGN_C   = CW'(3);
   localparam logic [CW-1:0] OFF_MAX_C = {1'b0, OFF_MAX};

   // configuration
   logic [31:0] txid_high_ff, txid_mid_ff, txid_low_ff;

   // parser state
   logic [W-1:0] off_ff, off_in;
   logic         hdr_ok_ff, hdr_ok_in;
   logic [15:0]  body_ff, body_in;
   logic [W-1:0] nxt_ff, nxt_in;
   logic [15:0]  kind_ff, kind_in;
   logic [15:0]  alen_ff, alen_in;
   logic [7:0]   fam_ff, fam_in;
   logic [15:0]  port_ff, port_in;
   logic [31:0]  addr_ff, addr_in;
   logic         best_found_ff, best_found_in;
   logic         best_xor_ff, best_xor_in;
   logic [15:0]  best_port_ff, best_port_in;
   logic [31:0]  best_addr_ff, best_addr_in;
   logic         stopped_ff, stopped_in;

   // result path
   logic        out_valid_ff, skid_valid_ff;
   verdict_type out_ff, skid_ff, verdict;

   logic          accept, push, pop;
   logic [W-1:0]  rel, v;
   logic          fin;
   logic [CW-1:0] nxt_sum, nxt_aligned;
   logic          ok;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign push      = accept && req_last_byte;
   assign pop       = out_valid_ff && rsp_ready;

   function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] sel);
      logic [7:0] r;
      case (sel)
         2'd0:    r = w[31:24];
         2'd1:    r = w[23:16];
         2'd2:    r = w[15:8];
         default: r = w[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [7:0] expected_byte(input logic [4:0] p,
                                                input logic [31:0] hi,
                                                input logic [31:0] mid,
                                                input logic [31:0] lo);
      logic [7:0] r;
      case (p[4:2])
         3'd0:    r = p[1] ? 8'h00 : (p[0] ? MSG_TYPE_BINDING_RSP[7:0]
                                           : MSG_TYPE_BINDING_RSP[15:8]);
         3'd1:    r = pick_byte(STUN_COOKIE, p[1:0]);
         3'd2:    r = pick_byte(hi, p[1:0]);
         3'd3:    r = pick_byte(mid, p[1:0]);
         3'd4:    r = pick_byte(lo, p[1:0]);
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         txid_high_ff <= '0;
         txid_mid_ff  <= '0;
         txid_low_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TXID_HIGH: txid_high_ff <= csr_data;
            CSR_TXID_MID:  txid_mid_ff  <= csr_data;
            CSR_TXID_LOW:  txid_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      off_in        = off_ff;
      hdr_ok_in     = hdr_ok_ff;
      body_in       = body_ff;
      nxt_in        = nxt_ff;
      kind_in       = kind_ff;
      alen_in       = alen_ff;
      fam_in        = fam_ff;
      port_in       = port_ff;
      addr_in       = addr_ff;
      best_found_in = best_found_ff;
      best_xor_in   = best_xor_ff;
      best_port_in  = best_port_ff;
      best_addr_in  = best_addr_ff;
      stopped_in    = stopped_ff;
      fin           = 1'b0;
      rel           = off_ff - nxt_ff;
      v             = rel - W'(ATTR_HDR);

      if (off_ff < HDR_W) begin
         case (off_ff[4:0])
            5'd2:    body_in = {req_data_byte, 8'h00};
            5'd3:    body_in = {body_ff[15:8], req_data_byte};
            default: begin
               if (req_data_byte != expected_byte(off_ff[4:0], txid_high_ff,
                                                   txid_mid_ff, txid_low_ff))
                  hdr_ok_in = 1'b0;
            end
         endcase
      end else if (off_ff == OFF_MAX) begin
         stopped_in = 1'b1;
      end else if (!stopped_ff && off_ff >= nxt_ff) begin
         if (rel == W'(0)) begin
            // attribute header must end inside the body
            if (({1'b0, nxt_ff} + ATTR_C) > (HDR_C + CW'(body_ff)))
               stopped_in = 1'b1;
            else
               kind_in = {req_data_byte, 8'h00};
         end else if (rel == W'(1)) begin
            kind_in = {kind_ff[15:8], req_data_byte};
         end else if (rel == W'(2)) begin
            alen_in = {req_data_byte, 8'h00};
         end else if (rel == W'(3)) begin
            alen_in = {alen_ff[15:8], req_data_byte};
            fin     = (alen_in == 16'd0);
         end else begin
            if (v == W'(1))
               fam_in = req_data_byte;
            else if (v == W'(2) || v == W'(3))
               port_in = {port_ff[7:0], req_data_byte};
            else if (v >= W'(4) && v <= W'(7))
               addr_in = {addr_ff[23:0], req_data_byte};
            fin = (alen_ff != 16'd0) && (v == W'(alen_ff - 16'd1));
         end
      end

      // close the attribute: capture on IPv4, advance to the padded next offset
      nxt_sum     = {1'b0, nxt_ff} + ATTR_C + CW'(alen_in) + ALIGN_C;
      nxt_aligned = nxt_sum & ~ALIGN_C;
      if (fin) begin
         if (alen_in >= 16'd8 && fam_in == FAMILY_V4) begin
            if (kind_in == KIND_XOR_MAPPED) begin
               best_found_in = 1'b1;
               best_xor_in   = 1'b1;
               best_port_in  = port_in ^ STUN_COOKIE[31:16];
               best_addr_in  = addr_in ^ STUN_COOKIE;
               stopped_in    = 1'b1;
            end else if (kind_in == KIND_MAPPED && !best_found_ff) begin
               best_found_in = 1'b1;
               best_xor_in   = 1'b0;
               best_port_in  = port_in;
               best_addr_in  = addr_in;
            end
         end
         nxt_in  = (nxt_aligned > OFF_MAX_C) ? OFF_MAX : nxt_aligned[W-1:0];
         fam_in  = '0;
         port_in = '0;
         addr_in = '0;
      end

      if (off_ff != OFF_MAX)
         off_in = off_ff + W'(1);

      ok = hdr_ok_in && (off_in >= HDR_W) &&
           ((HDR_C + CW'(body_in)) <= {1'b0, off_in}) && best_found_in;
      verdict.found       = ok;
      verdict.from_xor    = ok && best_xor_in;
      verdict.ip_address  = ok ? best_addr_in : 32'd0;
      verdict.mapped_port = ok ? best_port_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         // a verdict starts the next message from scratch
         off_ff        <= '0;
         hdr_ok_ff     <= 1'b1;
         body_ff       <= '0;
         nxt_ff        <= HDR_W;
         kind_ff       <= '0;
         alen_ff       <= '0;
         fam_ff        <= '0;
         port_ff       <= '0;
         addr_ff       <= '0;
         best_found_ff <= 1'b0;
         best_xor_ff   <= 1'b0;
         best_port_ff  <= '0;
         best_addr_ff  <= '0;
         stopped_ff    <= 1'b0;
      end else if (accept) begin
         off_ff        <= off_in;
         hdr_ok_ff     <= hdr_ok_in;
         body_ff       <= body_in;
         nxt_ff        <= nxt_in;
         kind_ff       <= kind_in;
         alen_ff       <= alen_in;
         fam_ff        <= fam_in;
         port_ff       <= port_in;
         addr_ff       <= addr_in;
         best_found_ff <= best_found_in;
         best_xor_ff   <= best_xor_in;
         best_port_ff  <= best_port_in;
         best_addr_ff  <= best_addr_in;
         stopped_ff    <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop)
            out_valid_ff <= 1'b1;
         else
            skid_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop)
            out_ff <= skid_ff;
      end else if (push) begin
         if (!out_valid_ff || pop)
            out_ff <= verdict;
         else
            skid_ff <= verdict;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_ff.found;
   assign rsp_from_xor    = out_ff.from_xor;
   assign rsp_ip_address  = out_ff.ip_address;
   assign rsp_mapped_port = out_ff.mapped_port;

endmodule

`default_nettype wire

// File: src/sbrp_checker.sv
// Port-level checks for the STUN binding response parser, bound to the top level.
// Depends on sbrp_pkg (csr index width) and the parser's port list.
`timescale 1ns / 1ps
`default_nettype none

module sbrp_checker
   import sbrp_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      req_last_byte,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_found,
   input wire logic                      rsp_from_xor,
   input wire logic [31:0]               rsp_ip_address,
   input wire logic [15:0]               rsp_mapped_port,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index
);

   // hold a stalled verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_from_xor) && $stable(rsp_ip_address) && $stable(rsp_mapped_port))
      else $error("stalled verdict changed");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> !rsp_from_xor && rsp_ip_address == 32'd0 &&
      rsp_mapped_port == 16'd0)
      else $error("verdict without address carries data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict present right after reset");

   // a final byte landing on a stalled full output fills the skid
   a_skid_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_valid && req_ready && req_last_byte |=> !req_ready)
      else $error("input still open with two verdicts pending");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready || csr_index == CSR_TXID_HIGH)
      else $error("register write stalled");

endmodule

bind stun_binding_response_parser sbrp_checker u_sbrp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_byte   (req_last_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found       (rsp_found),
   .rsp_from_xor    (rsp_from_xor),
   .rsp_ip_address  (rsp_ip_address),
   .rsp_mapped_port (rsp_mapped_port),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_index       (csr_index)
);

`default_nettype wire

// File: tb/stun_binding_response_parser_test.sv
// Self-checking test of the STUN binding response parser: streams whole messages in,
// predicts each verdict from the byte stream, and checks the verdicts coming out.
// Depends on sbrp_pkg and stun_binding_response_parser.
`timescale 1ns / 1ps

module stun_binding_response_parser_test;
   import sbrp_pkg::*;

   localparam int unsigned OB = OFFSET_BITS_DEFAULT;
   localparam int unsigned OFF_MAX = (1 << OB) - 1;
   localparam int unsigned QUIET_LIMIT = 500;
   localparam int unsigned PHASE_BYTES = 180;
   localparam int unsigned PHASE_MSGS = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic rsp_from_xor;
   logic [31:0] rsp_ip_address;
   logic [15:0] rsp_mapped_port;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TXID_HIGH;
   logic [31:0] csr_data = 32'h0;

   stun_binding_response_parser u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_from_xor(rsp_from_xor),
      .rsp_ip_address(rsp_ip_address),
      .rsp_mapped_port(rsp_mapped_port),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   msg_byte_type message_bytes[$];
   verdict_type verdicts_due[$];
   logic [7:0] msg_q[$];
   logic [31:0] txid_setting [3];
   int unsigned phase_bytes;
   int unsigned phase_msgs;
   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned ready_left = 0;
   int unsigned stall_left = 0;

   // Parser image: registers and per-message state
   logic [31:0] txid_high, txid_mid, txid_low;
   logic [OB-1:0] msg_pos;
   logic hdr_good;
   logic [15:0] body_size;
   logic [OB-1:0] attr_start;
   logic [15:0] attr_kind_r;
   logic [15:0] attr_len_r;
   logic [7:0] cap_family;
   logic [15:0] cap_port;
   logic [31:0] cap_addr;
   logic best_valid;
   logic best_xor;
   logic [15:0] best_port_r;
   logic [31:0] best_addr_r;
   logic walk_done;

   function automatic void clear_parser();
      msg_pos = '0;
      hdr_good = 1'b1;
      body_size = '0;
      attr_start = OB'(HDR_LEN);
      attr_kind_r = '0;
      attr_len_r = '0;
      cap_family = '0;
      cap_port = '0;
      cap_addr = '0;
      best_valid = 1'b0;
      best_xor = 1'b0;
      best_port_r = '0;
      best_addr_r = '0;
      walk_done = 1'b0;
   endfunction

   function automatic logic [7:0] header_ref_byte(int unsigned p);
      logic [31:0] w;
      case (p >> 2)
         0: w = {MSG_TYPE_BINDING_RSP, 16'h0000};
         1: w = STUN_COOKIE;
         2: w = txid_high;
         3: w = txid_mid;
         default: w = txid_low;
      endcase
      return w[8 * (3 - (p & 3)) +: 8];
   endfunction

   function automatic void close_attribute();
      int unsigned nxt;
      if (attr_len_r >= 8 && cap_family == FAMILY_V4) begin
         if (attr_kind_r == KIND_XOR_MAPPED) begin
            best_valid = 1'b1;
            best_xor = 1'b1;
            best_port_r = cap_port ^ STUN_COOKIE[31:16];
            best_addr_r = cap_addr ^ STUN_COOKIE;
            walk_done = 1'b1;
         end else if (attr_kind_r == KIND_MAPPED && !best_valid) begin
            best_valid = 1'b1;
            best_xor = 1'b0;
            best_port_r = cap_port;
            best_addr_r = cap_addr;
         end
      end
      // pad to the next 4-byte boundary, saturating at the top offset
      nxt = attr_start + 32'd4 + attr_len_r;
      nxt = (nxt + 32'd3) & ~32'd3;
      attr_start = (nxt > OFF_MAX) ? OB'(OFF_MAX) : OB'(nxt);
      cap_family = '0;
      cap_port = '0;
      cap_addr = '0;
   endfunction

   function automatic void walk_step(int unsigned p, logic [7:0] b);
      int unsigned rel;
      int unsigned v;
      if (walk_done || p < attr_start) return;
      rel = p - attr_start;
      if (rel == 0) begin
         if (attr_start + 32'd4 > HDR_LEN + body_size) begin
            walk_done = 1'b1;
            return;
         end
         attr_kind_r = {b, 8'h00};
      end else if (rel == 1) begin
         attr_kind_r[7:0] = b;
      end else if (rel == 2) begin
         attr_len_r = {b, 8'h00};
      end else if (rel == 3) begin
         attr_len_r[7:0] = b;
         if (attr_len_r == 0) close_attribute();
      end else begin
         v = rel - 4;
         if (v == 1) cap_family = b;
         else if (v == 2 || v == 3) cap_port = {cap_port[7:0], b};
         else if (v >= 4 && v <= 7) cap_addr = {cap_addr[23:0], b};
         if (v == attr_len_r - 32'd1) close_attribute();
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic last,
                                      output logic emit, output verdict_type v);
      int unsigned p;
      int unsigned len;
      logic ok;
      p = msg_pos;
      emit = 1'b0;
      v = '0;
      if (p < HDR_LEN) begin
         if (p == 2) body_size = {b, 8'h00};
         else if (p == 3) body_size[7:0] = b;
         else if (b != header_ref_byte(p)) hdr_good = 1'b0;
      end else if (p == OFF_MAX) begin
         walk_done = 1'b1;
      end else begin
         walk_step(p, b);
      end
      if (p < OFF_MAX) msg_pos = OB'(p + 1);
      if (!last) return;
      len = msg_pos;
      ok = hdr_good && len >= HDR_LEN && HDR_LEN + body_size <= len && best_valid;
      v.found = ok;
      v.from_xor = ok && best_xor;
      v.ip_address = ok ? best_addr_r : 32'h0;
      v.mapped_port = ok ? best_port_r : 16'h0;
      emit = 1'b1;
      clear_parser();
   endfunction

   // Monitor: check verdicts, track register writes, predict from accepted bytes
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      verdict_type next_v;
      logic emit;
      if (reset) begin
         txid_high = '0;
         txid_mid = '0;
         txid_low = '0;
         clear_parser();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_found, rsp_from_xor, rsp_ip_address, rsp_mapped_port};
            if (verdicts_due.size() == 0) begin
               if (fault_count < 10)
                  $display("%0t: unexpected verdict found=%0b xor=%0b addr=%h port=%h",
                           $realtime, got.found, got.from_xor, got.ip_address,
                           got.mapped_port);
               fault_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (got.found !== want.found || got.from_xor !== want.from_xor ||
                   got.ip_address !== want.ip_address ||
                   got.mapped_port !== want.mapped_port) begin
                  if (fault_count < 10)
                     $display({"%0t: verdict mismatch: expected found=%0b xor=%0b addr=%h ",
                               "port=%h, got found=%0b xor=%0b addr=%h port=%h"},
                              $realtime, want.found, want.from_xor, want.ip_address,
                              want.mapped_port, got.found, got.from_xor,
                              got.ip_address, got.mapped_port);
                  fault_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TXID_HIGH: txid_high = csr_data;
               CSR_TXID_MID: txid_mid = csr_data;
               CSR_TXID_LOW: txid_low = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, req_last_byte, emit, next_v);
            if (emit) verdicts_due.push_back(next_v);
         end
      end
   end

   // Driver: bursts of bytes with random gaps; hold each byte until taken
   always @(posedge clock) begin
      msg_byte_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (message_bytes.size() > 0) begin
            nb = message_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nb.data;
            req_last_byte <= nb.last;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: runs of ready with stalls in between, sometimes none
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_left > 0) begin
         ready_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         ready_left = $urandom_range(1, 24);
         stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(logic [31:0] w);
      msg_q.push_back(w[31:24]);
      msg_q.push_back(w[23:16]);
      msg_q.push_back(w[15:8]);
      msg_q.push_back(w[7:0]);
   endtask

   // Start a well-formed header; the body length is filled in by msg_close
   task automatic msg_begin();
      msg_q.delete();
      push_word({MSG_TYPE_BINDING_RSP, 16'h0000});
      push_word(STUN_COOKIE);
      push_word(txid_setting[CSR_TXID_HIGH]);
      push_word(txid_setting[CSR_TXID_MID]);
      push_word(txid_setting[CSR_TXID_LOW]);
   endtask

   task automatic msg_attr(logic [15:0] kind, int unsigned len, logic [7:0] family,
                           logic [15:0] port, logic [31:0] addr);
      int unsigned i;
      msg_q.push_back(kind[15:8]);
      msg_q.push_back(kind[7:0]);
      msg_q.push_back(len[15:8]);
      msg_q.push_back(len[7:0]);
      for (i = 0; i < len; i++) begin
         case (i)
            1: msg_q.push_back(family);
            2: msg_q.push_back(port[15:8]);
            3: msg_q.push_back(port[7:0]);
            4, 5, 6, 7: msg_q.push_back(addr[8 * (7 - i) +: 8]);
            default: msg_q.push_back(8'($urandom));
         endcase
      end
      while (msg_q.size() % 4 != 0) msg_q.push_back(8'($urandom));
   endtask

   task automatic msg_set_length(int unsigned n);
      msg_q[2] = n[15:8];
      msg_q[3] = n[7:0];
   endtask

   task automatic msg_close();
      msg_set_length(msg_q.size() - HDR_LEN);
   endtask

   task automatic msg_send();
      int unsigned i;
      for (i = 0; i < msg_q.size(); i++)
         message_bytes.push_back('{data: msg_q[i], last: (i == msg_q.size() - 1)});
      phase_bytes += msg_q.size();
      phase_msgs++;
   endtask

   task automatic build_random_message();
      int unsigned pick;
      int unsigned cut;
      logic [15:0] kind;
      msg_begin();
      repeat ($urandom_range(0, 4)) begin
         pick = $urandom_range(0, 9);
         kind = $urandom_range(0, 1) ? KIND_XOR_MAPPED : KIND_MAPPED;
         case (pick)
            0, 1, 2: msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
            3, 4, 5: msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
            6: msg_attr(kind, $urandom_range(8, 20), 8'h02, 16'($urandom), $urandom);
            7: msg_attr(kind, $urandom_range(0, 7), FAMILY_V4, 16'($urandom), $urandom);
            8: msg_attr(16'($urandom), $urandom_range(0, 24), 8'($urandom),
                        16'($urandom), $urandom);
            default: msg_attr(kind, $urandom_range(8, 12), 8'($urandom_range(0, 3)),
                              16'($urandom), $urandom);
         endcase
      end
      msg_close();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
      end else if (pick < 75) begin
         // corrupt one compared header byte
         cut = $urandom_range(0, 17);
         if (cut >= 2) cut += 2;
         msg_q[cut] = msg_q[cut] ^ 8'($urandom_range(1, 255));
      end else if (pick < 80) begin
         msg_set_length($urandom);
      end else if (pick < 85) begin
         msg_set_length($urandom_range(0, msg_q.size() - HDR_LEN));
      end else if (pick < 90) begin
         cut = $urandom_range(1, msg_q.size() - 1);
         repeat (cut) void'(msg_q.pop_back());
      end else if (pick < 95) begin
         repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
      end else begin
         msg_q.delete();
         repeat ($urandom_range(1, 40)) msg_q.push_back(8'($urandom));
      end
      msg_send();
   endtask

   task automatic run_random_phase();
      phase_bytes = 0;
      phase_msgs = 0;
      while (phase_bytes < PHASE_BYTES || phase_msgs < PHASE_MSGS) build_random_message();
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (message_bytes.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_txid(logic [31:0] hi, logic [31:0] mid, logic [31:0] lo);
      wait_idle();
      write_reg(CSR_TXID_HIGH, hi);
      write_reg(CSR_TXID_MID, mid);
      write_reg(CSR_TXID_LOW, lo);
      txid_setting[CSR_TXID_HIGH] = hi;
      txid_setting[CSR_TXID_MID] = mid;
      txid_setting[CSR_TXID_LOW] = lo;
   endtask

   initial begin
      txid_setting[CSR_TXID_HIGH] = '0;
      txid_setting[CSR_TXID_MID] = '0;
      txid_setting[CSR_TXID_LOW] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset values
      run_random_phase();

      set_txid($urandom, $urandom, $urandom);
      // header only, valid but nothing mapped
      msg_begin(); msg_close(); msg_send();
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'hFFFF, 32'hFFFF_FFFF);
      msg_close(); msg_send();
      msg_begin(); msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'h0000, 32'h0000_0000);
      msg_close(); msg_send();
      // XOR wins over an earlier plain address
      msg_begin(); msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_send();
      // walk stops after XOR, later plain is dropped
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_send();
      // first plain address is kept
      msg_begin(); msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_send();
      // IPv6 family ignored
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 20, 8'h02, 16'($urandom), $urandom);
      msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_send();
      // short attribute, padded odd length, zero length, then plain
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 4, FAMILY_V4, 16'($urandom), $urandom);
      msg_attr(16'h8022, 5, 8'($urandom), 16'($urandom), $urandom);
      msg_attr(KIND_XOR_MAPPED, 0, FAMILY_V4, 16'h0, 32'h0);
      msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_send();
      // bad message type, cookie, transaction id
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_q[1] = 8'h11; msg_send();
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_q[7] = msg_q[7] ^ 8'h80; msg_send();
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_close(); msg_q[19] = msg_q[19] ^ 8'h01; msg_send();
      // body length past the message end
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_set_length(msg_q.size() - 16); msg_send();
      // attribute header beyond the body
      msg_begin(); msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_set_length(0); msg_send();
      // XOR attribute cut off by the message end, plain one stands
      msg_begin(); msg_attr(KIND_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      msg_attr(KIND_XOR_MAPPED, 8, FAMILY_V4, 16'($urandom), $urandom);
      repeat (3) void'(msg_q.pop_back());
      msg_close(); msg_send();
      // runt messages
      msg_q.delete(); msg_q.push_back(8'h01); msg_send();
      msg_begin(); void'(msg_q.pop_back()); msg_send();

      set_txid('1, '1, '1);
      run_random_phase();
      set_txid('0, '0, '0);
      run_random_phase();
      set_txid($urandom, $urandom, $urandom);
      run_random_phase();
      set_txid($urandom, $urandom, $urandom);
      run_random_phase();

      wait_idle();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && verdicts_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
src/sbrp_pkg.sv
src/stun_binding_response_parser.sv
src/sbrp_checker.sv
tb/stun_binding_response_parser_test.sv
